// File: rtl/epwm_pkg.sv
// ----------------------------------------------------------------------------
// epwm_pkg
// Shared types and constants for the executable page whitelist monitor.
// ----------------------------------------------------------------------------
package epwm_pkg;

    // default geometry
    localparam int TRACKED_PAGES_DEF = 1048576;
    localparam int PAGE_SHIFT_DEF    = 12;

    // bitmap memory row
    localparam int ROW_BITS  = 32;
    localparam int ROW_SHIFT = $clog2(ROW_BITS);

    // field widths
    localparam int ADDR_W  = 52;
    localparam int IP_W    = 64;
    localparam int COUNT_W = 21;
    localparam int IMAGE_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [IMAGE_W-1:0] IMAGE_MAX = '1;

    // operation selector codes
    localparam logic [1:0] FUNC_REGISTER = 2'd0;
    localparam logic [1:0] FUNC_CHECK    = 2'd1;
    localparam logic [1:0] FUNC_QUERY    = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    // operation kind after enable and length are applied
    typedef enum logic [1:0] {
        OP_NONE,
        OP_CHECK,
        OP_QUERY
    } t_op;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] phys_address;
        logic [ADDR_W-1:0] image_length;
        logic [IP_W-1:0]   guest_ip;
        logic [ADDR_W-1:0] guest_root;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_W-1:0] new_pages;
        logic               injection;
        logic               known;
        logic               alert_valid;
        logic [IP_W-1:0]    alert_ip;
        logic [ADDR_W-1:0]  alert_root;
        logic [ADDR_W-1:0]  alert_address;
        logic [ADDR_W-1:0]  alert_info;
        logic [IMAGE_W-1:0] image_total;
        logic [COUNT_W-1:0] page_total;
    } t_out_beat;

    // single-page lookup waiting for its bitmap row
    typedef struct packed {
        t_op                 op;
        logic [ROW_SHIFT-1:0] bit_off;
        logic                tracked;
        logic [ADDR_W-1:0]   phys_address;
        logic [IP_W-1:0]     guest_ip;
        logic [ADDR_W-1:0]   guest_root;
    } t_lookup;

endpackage

// File: rtl/exec_page_whitelist_monitor_core.sv
// ----------------------------------------------------------------------------
// exec_page_whitelist_monitor_core
// Page bitmap of legitimate code pages with image registration, execute
// checks and known-page queries.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | beat
//  ---------+-----------+------------------------+-----------
//  in       | input     | i_in_valid/o_in_ready  | t_in_beat
//  out      | output    | o_out_valid/i_out_ready| t_out_beat
//  cfg      | input     | i_cfg_we (no wait)     | i_cfg_data
//
//  Check, query and no-op beats: one per cycle unless the output stalls; each
//  reads its row through the single registered read port of the bitmap memory.
//  Register beats walk the bitmap rows of 32 pages spanned by the
//  image; the walk does one read-modify-write of a row per cycle. A register
//  beat whose base page is untracked skips the walk.
//  After reset a clearing pass writes TRACKED_PAGES/32 rows (rounded up),
//  one per cycle, with o_in_ready low; configuration writes are taken always.
//  A stalled output holds its beat; the next lookup is still taken while
//  the output register drains in the same cycle.
// ----------------------------------------------------------------------------
module exec_page_whitelist_monitor_core
    import epwm_pkg::*;
#(
    parameter int TRACKED_PAGES = TRACKED_PAGES_DEF,
    parameter int PAGE_SHIFT    = PAGE_SHIFT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data
);

    localparam int ROWS   = (TRACKED_PAGES + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TRK_W  = $clog2(TRACKED_PAGES + 1);
    localparam int SUM_W  = ((TRK_W > COUNT_W) ? TRK_W : COUNT_W) + 1;
    localparam int END_W  = ADDR_W + 2;
    localparam logic [END_W-1:0]    PAGE_M1 = END_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [END_W-1:0]    TRK_END = END_W'(TRACKED_PAGES);
    localparam logic [ROW_W-1:0]    ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [ROW_BITS-1:0] ONES = '1;

    // state
    t_state r_state, n_state;

    logic [ROW_BITS-1:0] r_mem [ROWS];
    logic [ROW_BITS-1:0] r_rd_data;

    logic               r_enabled;
    logic [IMAGE_W-1:0] r_image_count;
    logic [COUNT_W-1:0] r_page_count;
    logic [ROW_W-1:0]   r_clr;

    logic               r_s1_valid;
    t_lookup            r_s1;

    logic [TRK_W-1:0]   r_first, r_last, r_acc;
    logic [ROW_W-1:0]   r_rd_row, r_pend_row;
    logic               r_rd_more, r_pend;

    logic               r_out_valid;
    t_out_beat          r_out_beat;

    // control decoded each cycle
    logic               out_free, in_acc, is_reg, reg_walk;
    logic               rd_en, wr_en, out_load;
    logic [ROW_W-1:0]   rd_addr, wr_addr;
    logic [ROW_BITS-1:0] wr_data;
    t_out_beat          n_out_beat;

    // address decode of the incoming beat
    logic [ADDR_W-1:0]  in_page;
    logic               in_tracked;
    logic [END_W-1:0]   in_end_full;
    logic [END_W-1:0]   in_last_full;
    logic [TRK_W-1:0]   in_last;
    t_op                in_op;

    always_comb begin
        in_page      = i_in_beat.phys_address >> PAGE_SHIFT;
        in_tracked   = {2'b00, in_page} < TRK_END;
        in_end_full  = {2'b00, i_in_beat.phys_address} + {2'b00, i_in_beat.image_length}
                       + PAGE_M1;
        in_last_full = in_end_full >> PAGE_SHIFT;
        in_last      = (in_last_full > TRK_END) ? TRK_W'(TRACKED_PAGES)
                                                : TRK_W'(in_last_full);
        is_reg       = r_enabled && (i_in_beat.func == FUNC_REGISTER)
                       && (i_in_beat.image_length != '0);
        reg_walk     = is_reg && in_tracked;
        if (!r_enabled) begin
            in_op = OP_NONE;
        end else if (i_in_beat.func == FUNC_CHECK) begin
            in_op = OP_CHECK;
        end else if (i_in_beat.func == FUNC_QUERY) begin
            in_op = OP_QUERY;
        end else begin
            in_op = OP_NONE;
        end
    end

    // walk row bounds and mask of the row in flight
    logic [TRK_W-1:0]     last_m1;
    logic [ROW_W-1:0]     first_row, last_row;
    logic [ROW_SHIFT-1:0] lo, hi;
    logic [ROW_BITS-1:0]  mask, newly;

    always_comb begin
        last_m1   = r_last - TRK_W'(1);
        first_row = ROW_W'(r_first >> ROW_SHIFT);
        last_row  = ROW_W'(last_m1 >> ROW_SHIFT);
        lo        = (r_pend_row == first_row) ? r_first[ROW_SHIFT-1:0] : '0;
        hi        = (r_pend_row == last_row) ? last_m1[ROW_SHIFT-1:0] : '1;
        mask      = (ONES << lo) & (ONES >> (~hi));
        newly     = mask & ~r_rd_data;
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign in_acc   = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == ROW_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc && is_reg) n_state = reg_walk ? S_WALK : S_DONE;
            end
            S_WALK: begin
                if (!r_rd_more && !r_pend) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // memory and handshake controls
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_rd_row;
        wr_en      = 1'b0;
        wr_addr    = r_pend_row;
        wr_data    = r_rd_data | mask;
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
            end
            S_IDLE: begin
                o_in_ready = !r_s1_valid || out_free;
                rd_en      = in_acc && !is_reg;
                rd_addr    = ROW_W'(in_page >> ROW_SHIFT);
            end
            S_WALK: begin
                rd_en = r_rd_more;
                wr_en = r_pend;
            end
            default: ;
        endcase
    end

    // result assembly
    logic               s1_bit;
    logic [SUM_W-1:0]   page_sum, acc_ext;
    logic [COUNT_W-1:0] n_page_count;
    logic [IMAGE_W-1:0] n_image_count;

    always_comb begin
        s1_bit        = r_rd_data[r_s1.bit_off];
        acc_ext       = SUM_W'(r_acc);
        page_sum      = SUM_W'(r_page_count) + acc_ext;
        n_page_count  = (page_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(page_sum);
        n_image_count = (r_image_count == IMAGE_MAX) ? r_image_count
                                                     : r_image_count + IMAGE_W'(1);
        n_out_beat             = '0;
        n_out_beat.image_total = r_image_count;
        n_out_beat.page_total  = r_page_count;
        out_load               = 1'b0;
        if (r_state == S_DONE) begin
            out_load               = out_free;
            n_out_beat.new_pages   = (acc_ext > SUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                                   : COUNT_W'(r_acc);
            n_out_beat.image_total = n_image_count;
            n_out_beat.page_total  = n_page_count;
        end else if (r_s1_valid) begin
            out_load = out_free;
            if (r_s1.op == OP_CHECK && (!r_s1.tracked || !s1_bit)) begin
                n_out_beat.injection     = 1'b1;
                n_out_beat.alert_valid   = 1'b1;
                n_out_beat.alert_ip      = r_s1.guest_ip;
                n_out_beat.alert_root    = r_s1.guest_root;
                n_out_beat.alert_address = r_s1.phys_address;
                n_out_beat.alert_info    = r_s1.tracked ? r_s1.guest_root : '0;
            end
            n_out_beat.known = (r_s1.op == OP_QUERY) && r_s1.tracked && s1_bit;
        end
    end

    // bitmap memory, write port
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    // bitmap memory, registered read port
    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_enabled     <= 1'b1;
            r_image_count <= '0;
            r_page_count  <= '0;
            r_clr         <= '0;
            r_s1_valid    <= 1'b0;
            r_rd_more     <= 1'b0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_enabled <= i_cfg_data;
            if (r_state == S_CLEAR) r_clr <= r_clr + ROW_W'(1);
            // lookup stage refills on accept, else empties into the output
            if (in_acc && !is_reg) begin
                r_s1_valid <= 1'b1;
            end else if (out_load && r_state != S_DONE) begin
                r_s1_valid <= 1'b0;
            end
            // walk read sequencing
            if (in_acc && reg_walk) r_rd_more <= 1'b1;
            if (r_state == S_WALK && r_rd_more && r_rd_row == last_row) r_rd_more <= 1'b0;
            r_pend <= (r_state == S_WALK) && r_rd_more;
            // totals move only when a registration completes
            if (r_state == S_DONE && out_free) begin
                r_image_count <= n_image_count;
                r_page_count  <= n_page_count;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && !is_reg) begin
            r_s1.op           <= in_op;
            r_s1.bit_off      <= in_page[ROW_SHIFT-1:0];
            r_s1.tracked      <= in_tracked;
            r_s1.phys_address <= i_in_beat.phys_address;
            r_s1.guest_ip     <= i_in_beat.guest_ip;
            r_s1.guest_root   <= i_in_beat.guest_root;
        end
        if (in_acc && is_reg) begin
            r_first  <= TRK_W'(in_page);
            r_last   <= in_last;
            r_rd_row <= ROW_W'(in_page >> ROW_SHIFT);
            r_acc    <= '0;
        end
        if (r_state == S_WALK && r_rd_more) begin
            r_rd_row   <= r_rd_row + ROW_W'(1);
            r_pend_row <= r_rd_row;
        end
        if (r_state == S_WALK && r_pend) r_acc <= r_acc + TRK_W'($countones(newly));
        if (out_load) r_out_beat <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// File: rtl/epwm_checker.sv
// ----------------------------------------------------------------------------
// epwm_checker
// Port-level assertions for the executable page whitelist monitor.
// ----------------------------------------------------------------------------
module epwm_checker
    import epwm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_beat
);

    // a beat is never both a check alert and a query hit
    a_inj_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_beat.injection && o_out_beat.known))
        else $error("injection and known both set");

    // alert flag tracks injection, alert fields clear without it
    a_alert_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.injection) |->
            (!o_out_beat.alert_valid && o_out_beat.alert_ip == '0
             && o_out_beat.alert_info == '0 && o_out_beat.alert_address == '0))
        else $error("alert fields without injection");

    // newly marked pages are part of the running page total
    a_new_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.new_pages <= o_out_beat.page_total))
        else $error("new pages exceed page total");

    // a registration beat carries no check or query flags
    a_reg_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.new_pages != '0) |->
            (!o_out_beat.injection && !o_out_beat.known))
        else $error("flags on registration beat");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("output beat changed while stalled");

endmodule

bind exec_page_whitelist_monitor_core epwm_checker u_epwm_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the executable page whitelist monitor. A queue of
// pending beats feeds a valid/ready driver with random gaps; a monitor
// compares every result beat with a bit-level page bitmap predictor, field
// by field. Phases toggle the enable register between drained runs.
// ----------------------------------------------------------------------------
module testbench;
    import epwm_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int TRACKED        = TRACKED_PAGES_DEF;
    localparam int PAGE_BYTES     = 1 << PAGE_SHIFT_DEF;
    localparam int HOT_FIRST      = 256;
    localparam int HOT_SPAN       = 512;
    localparam int IDLE_TAIL      = 8;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_A      = 150;
    localparam int HOLD_AT_B      = 800;
    localparam int TIMEOUT_CYCLES = 1000000;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
    localparam logic [IP_W-1:0]   IP_ONES   = '1;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_beat  in_beat  = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;
    logic      cfg_we   = 1'b0;
    logic      cfg_data = 1'b0;

    // predictor state
    bit                 page_mark [TRACKED];
    logic [IMAGE_W-1:0] images_seen = '0;
    logic [COUNT_W-1:0] pages_seen  = '0;
    bit                 monitor_on  = 1'b1;

    t_in_beat    pending_beats[$];
    t_out_beat   expected_results[$];
    t_out_beat   oldest_expect;
    int unsigned fail_count = 0;

    int unsigned tx_wait = 0;
    int unsigned tx_sent = 0;
    int unsigned tx_draw;
    int unsigned rx_wait = 0;
    int unsigned rx_seen = 0;
    int unsigned rx_draw;

    exec_page_whitelist_monitor_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    // clock
    always begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // expected result of one accepted beat, updates the bitmap copy
    function automatic t_out_beat predict_whitelist(t_in_beat b);
        t_out_beat       r;
        longint unsigned addr;
        longint unsigned len;
        longint unsigned pg;
        longint unsigned last;
        longint unsigned p;
        longint unsigned fresh;
        bit              tracked;
        r = '0;
        addr = 64'(b.phys_address);
        len = 64'(b.image_length);
        pg = addr >> PAGE_SHIFT_DEF;
        tracked = pg < TRACKED;
        fresh = 0;
        if (monitor_on) begin
            case (b.func)
                FUNC_REGISTER: begin
                    if (len != 0) begin
                        last = (addr + len + PAGE_BYTES - 1) >> PAGE_SHIFT_DEF;
                        if (last > TRACKED) last = TRACKED;
                        for (p = pg; p < last; p++) begin
                            if (!page_mark[p]) begin
                                page_mark[p] = 1'b1;
                                fresh++;
                            end
                        end
                        if (images_seen != IMAGE_MAX) images_seen++;
                        if (64'(pages_seen) + fresh > 64'(COUNT_MAX)) pages_seen = COUNT_MAX;
                        else pages_seen = pages_seen + COUNT_W'(fresh);
                        r.new_pages = (fresh > 64'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(fresh);
                    end
                end
                FUNC_CHECK: begin
                    if (!tracked || !page_mark[pg]) begin
                        r.injection     = 1'b1;
                        r.alert_valid   = 1'b1;
                        r.alert_ip      = b.guest_ip;
                        r.alert_root    = b.guest_root;
                        r.alert_address = b.phys_address;
                        r.alert_info    = tracked ? b.guest_root : '0;
                    end
                end
                FUNC_QUERY: begin
                    r.known = tracked && page_mark[pg];
                end
                default: ;
            endcase
        end
        r.image_total = images_seen;
        r.page_total  = pages_seen;
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(t_out_beat want, t_out_beat got);
        compare_field("new_pages", 64'(want.new_pages), 64'(got.new_pages));
        compare_field("injection", 64'(want.injection), 64'(got.injection));
        compare_field("known", 64'(want.known), 64'(got.known));
        compare_field("alert_valid", 64'(want.alert_valid), 64'(got.alert_valid));
        compare_field("alert_ip", want.alert_ip, got.alert_ip);
        compare_field("alert_root", 64'(want.alert_root), 64'(got.alert_root));
        compare_field("alert_address", 64'(want.alert_address), 64'(got.alert_address));
        compare_field("alert_info", 64'(want.alert_info), 64'(got.alert_info));
        compare_field("image_total", 64'(want.image_total), 64'(got.image_total));
        compare_field("page_total", 64'(want.page_total), 64'(got.page_total));
    endtask

    function automatic int unsigned draw_gap(bit no_idle);
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    // input driver: offers queued beats, predicts each accepted one
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_wait  <= 0;
        end else if (in_valid && in_ready) begin
            expected_results.push_back(predict_whitelist(in_beat));
            tx_sent++;
            tx_draw = draw_gap(((tx_sent / 40) % 3) == 2);
            if (pending_beats.size() != 0 && tx_draw == 0) begin
                in_beat <= pending_beats.pop_front();
            end else begin
                in_valid <= 1'b0;
                tx_wait  <= tx_draw;
            end
        end else if (!in_valid) begin
            if (tx_wait != 0) begin
                tx_wait <= tx_wait - 1;
            end else if (pending_beats.size() != 0) begin
                in_beat  <= pending_beats.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // output receiver: random back-pressure plus two long hold-offs
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end else if (out_ready && out_valid) begin
            if (rx_seen == HOLD_AT_A || rx_seen == HOLD_AT_B) rx_draw = LONG_HOLD;
            else rx_draw = draw_gap(((rx_seen / 55) % 3) == 1);
            rx_seen++;
            if (rx_draw != 0) begin
                out_ready <= 1'b0;
                rx_wait   <= rx_draw;
            end
        end else if (!out_ready) begin
            if (rx_wait == 0) out_ready <= 1'b1;
            else rx_wait <= rx_wait - 1;
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat arrived with no expectation pending");
                fail_count++;
            end else begin
                oldest_expect = expected_results.pop_front();
                check_result(oldest_expect, out_beat);
            end
        end
    end

    function automatic t_in_beat make_beat(logic [1:0] func, logic [ADDR_W-1:0] addr,
                                           logic [ADDR_W-1:0] len, logic [IP_W-1:0] ip,
                                           logic [ADDR_W-1:0] root);
        t_in_beat b;
        b.func         = func;
        b.phys_address = addr;
        b.image_length = len;
        b.guest_ip     = ip;
        b.guest_root   = root;
        return b;
    endfunction

    function automatic logic [ADDR_W-1:0] rand52();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [IP_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] page_addr(longint unsigned pg);
        longint unsigned off;
        off = $urandom_range(0, PAGE_BYTES - 1);
        return ADDR_W'((pg << PAGE_SHIFT_DEF) | off);
    endfunction

    // addresses bunched where images live, near the tracked limit, or anywhere
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return page_addr(HOT_FIRST + $urandom_range(0, HOT_SPAN - 1));
        if (sel < 70) return page_addr(TRACKED - 48 + $urandom_range(0, 95));
        if (sel < 85) return page_addr($urandom_range(0, TRACKED - 1));
        return rand52();
    endfunction

    function automatic t_in_beat rand_beat();
        int unsigned       sel;
        logic [ADDR_W-1:0] len;
        sel = $urandom_range(0, 99);
        if (sel < 45) return make_beat(FUNC_CHECK, pick_address(), rand52(), rand64(), rand52());
        if (sel < 70) return make_beat(FUNC_QUERY, pick_address(), rand52(), rand64(), rand52());
        if (sel < 80) begin
            len = ($urandom_range(0, 9) == 0) ? '0 : ADDR_W'($urandom_range(1, 3 * PAGE_BYTES));
            return make_beat(FUNC_REGISTER, pick_address(), len, rand64(), rand52());
        end
        // wide lengths only from bases near or past the tracked limit
        if (sel < 92) begin
            if ($urandom_range(0, 1) == 0)
                return make_beat(FUNC_REGISTER, page_addr(TRACKED - 8 + $urandom_range(0, 15)),
                                 rand52(), rand64(), rand52());
            return make_beat(FUNC_REGISTER, rand52(), rand52(), rand64(), rand52());
        end
        return make_beat(FUNC_UNUSED, rand52(), rand52(), rand64(), rand52());
    endfunction

    // mostly image registrations followed by probes in and around them
    task automatic queue_random(int unsigned count);
        int unsigned       n;
        int unsigned       follow;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] probe;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 2) == 0) begin
                base = page_addr(HOT_FIRST + $urandom_range(0, HOT_SPAN - 1));
                len = ADDR_W'($urandom_range(1, 6 * PAGE_BYTES));
                pending_beats.push_back(make_beat(FUNC_REGISTER, base, len, rand64(), rand52()));
                n++;
                follow = $urandom_range(2, 8);
                repeat (follow) begin
                    probe = base + ADDR_W'($urandom_range(0, 32'(len) + PAGE_BYTES));
                    if ($urandom_range(0, 5) == 0) probe = base - ADDR_W'($urandom_range(1, 2 * PAGE_BYTES));
                    pending_beats.push_back(make_beat(($urandom_range(0, 2) == 0) ? FUNC_QUERY
                                                                                   : FUNC_CHECK,
                                                      probe, rand52(), rand64(), rand52()));
                    n++;
                end
            end else begin
                pending_beats.push_back(rand_beat());
                n++;
            end
        end
    endtask

    // waits until every queued beat is sent and every result is back, polled between clock edges
    task automatic wait_drained();
        @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_enable(bit value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        monitor_on = value;
    endtask

    task automatic queue_directed();
        // empty bitmap, untracked addresses, zero length
        pending_beats.push_back(make_beat(FUNC_QUERY, '0, '0, '0, '0));
        pending_beats.push_back(make_beat(FUNC_CHECK, '0, ADDR_ONES, IP_ONES, ADDR_ONES));
        pending_beats.push_back(make_beat(FUNC_CHECK, ADDR_ONES, '0, '0, rand52()));
        pending_beats.push_back(make_beat(FUNC_QUERY, ADDR_ONES, ADDR_ONES, IP_ONES, ADDR_ONES));
        pending_beats.push_back(make_beat(FUNC_REGISTER, 52'h5000, '0, rand64(), rand52()));
        // small images, overlap and re-registration
        pending_beats.push_back(make_beat(FUNC_REGISTER, 52'h1234, 52'd1, rand64(), rand52()));
        pending_beats.push_back(make_beat(FUNC_REGISTER, 52'h0FFF, 52'd2, rand64(), rand52()));
        pending_beats.push_back(make_beat(FUNC_QUERY, 52'h1FFF, '0, '0, '0));
        pending_beats.push_back(make_beat(FUNC_CHECK, 52'h1000, '0, rand64(), rand52()));
        pending_beats.push_back(make_beat(FUNC_REGISTER, 52'h0FFF, 52'd2, rand64(), rand52()));
        pending_beats.push_back(make_beat(FUNC_REGISTER, ADDR_W'(31 * PAGE_BYTES + 5),
                                          ADDR_W'(PAGE_BYTES), rand64(), rand52()));
        // walk clipped at the tracked limit
        pending_beats.push_back(make_beat(FUNC_REGISTER, ADDR_W'(64'(TRACKED - 3) * PAGE_BYTES),
                                          ADDR_ONES, rand64(), rand52()));
        pending_beats.push_back(make_beat(FUNC_CHECK,
                                          ADDR_W'(64'(TRACKED) * PAGE_BYTES - 1),
                                          '0, rand64(), rand52()));
        pending_beats.push_back(make_beat(FUNC_CHECK, ADDR_W'(64'(TRACKED) * PAGE_BYTES),
                                          '0, rand64(), rand52()));
        pending_beats.push_back(make_beat(FUNC_QUERY, ADDR_W'(64'(TRACKED) * PAGE_BYTES),
                                          '0, '0, '0));
        pending_beats.push_back(make_beat(FUNC_REGISTER, ADDR_W'(64'(TRACKED) * PAGE_BYTES),
                                          ADDR_ONES, rand64(), rand52()));
        pending_beats.push_back(make_beat(FUNC_REGISTER, ADDR_ONES, ADDR_ONES, IP_ONES, ADDR_ONES));
        // unused selector
        pending_beats.push_back(make_beat(FUNC_UNUSED, ADDR_ONES, ADDR_ONES, IP_ONES, ADDR_ONES));
        pending_beats.push_back(make_beat(FUNC_UNUSED, '0, '0, '0, '0));
        // one medium image spanning many rows
        pending_beats.push_back(make_beat(FUNC_REGISTER, 52'h1000_0000, 52'h400_0000,
                                          rand64(), rand52()));
        pending_beats.push_back(make_beat(FUNC_QUERY, 52'h13FF_FFFF, '0, '0, '0));
        pending_beats.push_back(make_beat(FUNC_CHECK, 52'h1400_0000, '0, rand64(), rand52()));
        pending_beats.push_back(make_beat(FUNC_CHECK, 52'h1200_0ABC, '0, rand64(), rand52()));
    endtask

    // run sequence
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_enable(1'b1);
        queue_directed();
        wait_drained();
        queue_random(450);
        wait_drained();
        write_enable(1'b0);
        queue_random(150);
        wait_drained();
        write_enable(1'b1);
        queue_random(450);
        wait_drained();
        // whole tracked space in one image, then probes
        pending_beats.push_back(make_beat(FUNC_REGISTER, '0, ADDR_ONES, rand64(), rand52()));
        repeat (6) pending_beats.push_back(make_beat(($urandom_range(0, 1) == 0) ? FUNC_CHECK
                                                                                : FUNC_QUERY,
                                                     pick_address(), rand52(), rand64(),
                                                     rand52()));
        wait_drained();
        write_enable(1'b0);
        queue_random(8);
        wait_drained();
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/epwm_pkg.sv
rtl/exec_page_whitelist_monitor_core.sv
rtl/epwm_checker.sv
bench/testbench.sv
